>>> hdl/jtsc_pkg.sv
// ----------------------------------------------------------------------------
// JSON token structure checker - shared package
// Token, status and event codes, context modes, flag bits and port widths.
// ----------------------------------------------------------------------------
package jtsc_pkg;

  // Token kinds from the upstream tokenizer
  localparam logic [4:0] TOK_EOF      = 5'd0;
  localparam logic [4:0] TOK_ERROR    = 5'd1;
  localparam logic [4:0] TOK_LCOMMENT = 5'd2;
  localparam logic [4:0] TOK_BCOMMENT = 5'd3;
  localparam logic [4:0] TOK_LBRACKET = 5'd4;
  localparam logic [4:0] TOK_RBRACKET = 5'd5;
  localparam logic [4:0] TOK_LBRACE   = 5'd6;
  localparam logic [4:0] TOK_RBRACE   = 5'd7;
  localparam logic [4:0] TOK_COMMA    = 5'd8;
  localparam logic [4:0] TOK_COLON    = 5'd9;
  localparam logic [4:0] TOK_SQ_STR   = 5'd10;
  localparam logic [4:0] TOK_DQ_STR   = 5'd11;
  localparam logic [4:0] TOK_IDENT    = 5'd12;
  localparam logic [4:0] TOK_TRUE     = 5'd13;
  localparam logic [4:0] TOK_FALSE    = 5'd14;
  localparam logic [4:0] TOK_NULL     = 5'd15;
  localparam logic [4:0] TOK_DECIMAL  = 5'd16;
  localparam logic [4:0] TOK_DOUBLE   = 5'd17;
  localparam logic [4:0] TOK_HEX      = 5'd18;

  // Result status codes
  localparam logic [2:0] ST_EVENT   = 3'd0;
  localparam logic [2:0] ST_COMMENT = 3'd1;
  localparam logic [2:0] ST_EOF     = 3'd2;
  localparam logic [2:0] ST_TRUNC   = 3'd3;
  localparam logic [2:0] ST_BADTOK  = 3'd4;
  localparam logic [2:0] ST_BADST   = 3'd5;
  localparam logic [2:0] ST_TOKERR  = 3'd6;

  // Parse event kinds
  localparam logic [3:0] EV_NONE = 4'd0;
  localparam logic [3:0] EV_OSTA = 4'd1;
  localparam logic [3:0] EV_OEND = 4'd2;
  localparam logic [3:0] EV_ASTA = 4'd3;
  localparam logic [3:0] EV_AEND = 4'd4;
  localparam logic [3:0] EV_PROP = 4'd5;
  localparam logic [3:0] EV_STR  = 4'd6;
  localparam logic [3:0] EV_INT  = 4'd7;
  localparam logic [3:0] EV_DBL  = 4'd8;
  localparam logic [3:0] EV_BOOL = 4'd9;
  localparam logic [3:0] EV_NULL = 4'd10;

  // Context modes
  localparam logic [1:0] MODE_ROOT   = 2'd0;
  localparam logic [1:0] MODE_ARRAY  = 2'd1;
  localparam logic [1:0] MODE_OBJECT = 2'd2;

  // Context flags
  localparam logic [3:0] F_PROP  = 4'b0001;
  localparam logic [3:0] F_COLON = 4'b0010;
  localparam logic [3:0] F_VALUE = 4'b0100;
  localparam logic [3:0] F_COMMA = 4'b1000;
  localparam logic [3:0] F_ALL   = 4'b1111;
  localparam logic [3:0] F_PC    = F_PROP | F_COLON;
  localparam logic [3:0] F_PCV   = F_PROP | F_COLON | F_VALUE;
  localparam logic [3:0] F_VC    = F_VALUE | F_COMMA;

  // Saved context word: mode in the upper bits, flags below
  localparam int CTX_W = 6;

  // Stream widths
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 80;

  typedef logic [CTX_W-1:0] ctx_word_t;

endpackage

>>> hdl/jtsc_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module jtsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write the entry on enable
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/json_token_structure_checker_top.sv
// ----------------------------------------------------------------------------
// JSON token structure checker - top level
// Checks a token stream against the JSON grammar (optionally JSON5) and
// emits one parse event or status word per token.
//
//   channel  | dir | handshake              | payload
//   ---------+-----+------------------------+-------------------------------
//   s_       | in  | s_tvalid / s_tready    | s_tdata: token_kind, value_bits
//   m_       | out | m_tvalid / m_tready    | m_tdata: status, event_kind,
//            |     |                        |   bool_value, value_out, depth
//   cfg_     | in  | cfg_valid / cfg_ready  | cfg_data: json5_enable
//
// One token per cycle while s_tready is high; the registered result appears
// in the cycle after the transfer. The saved-context stack lives in a RAM
// with registered read data; the top entry is read ahead every cycle, with
// the last pushed word forwarded. Reset clears the mode, flags, stack pointer
// and json5_enable; no clearing pass is needed. A stalled output holds its
// result and s_tready drops only while that result waits and m_tready is low.
// ----------------------------------------------------------------------------
module json_token_structure_checker_top #(
  parameter int MAX_DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  // [4:0] token_kind, [68:5] value_bits, [71:69] zero
  input  logic [jtsc_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [2:0] status, [6:3] event_kind, [7] bool_value, [71:8] value_out,
  // [77:72] nesting_depth, [79:78] zero
  output logic [jtsc_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic                            cfg_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready
);

  import jtsc_pkg::*;

  localparam int SP_W   = $clog2(MAX_DEPTH + 1);
  localparam int ADDR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  // Architectural state
  logic            json5;
  logic [1:0]      mode;
  logic [3:0]      flags;
  logic [SP_W-1:0] sp;
  logic            push_d;
  ctx_word_t       push_word_d;

  // Step results
  logic [1:0]      mode_next;
  logic [3:0]      flags_next;
  logic [SP_W-1:0] sp_next;
  logic            push;
  ctx_word_t       push_word;
  logic [2:0]      st;
  logic [3:0]      ev;
  logic            bv;
  logic [63:0]     val;

  // Primitive classification
  logic            prim_ok;
  logic [3:0]      prim_ev;
  logic            is_val;

  logic [4:0]      tok;
  logic [63:0]     bits;
  logic            accept;
  ctx_word_t       top_word;
  ctx_word_t       ram_rdata;

  assign tok    = s_tdata[4:0];
  assign bits   = s_tdata[68:5];
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Take the freshly pushed word until the RAM has it
  assign top_word = push_d ? push_word_d : ram_rdata;

  // Stack storage
  jtsc_ram #(
    .WIDTH (CTX_W),
    .DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (push),
    .waddr (ADDR_W'(sp)),
    .wdata (push_word),
    .raddr (ADDR_W'(sp_next - SP_W'(1))),
    .rdata (ram_rdata)
  );

  // Classify a primitive value token
  always_comb begin
    prim_ok = 1'b1;
    prim_ev = EV_NONE;
    unique case (tok)
      TOK_DQ_STR: prim_ev = EV_STR;
      TOK_TRUE, TOK_FALSE: prim_ev = EV_BOOL;
      TOK_NULL: prim_ev = EV_NULL;
      TOK_DECIMAL: prim_ev = EV_INT;
      TOK_DOUBLE: prim_ev = EV_DBL;
      TOK_SQ_STR, TOK_IDENT: begin
        prim_ev = EV_STR;
        prim_ok = json5;
      end
      TOK_HEX: begin
        prim_ev = EV_INT;
        prim_ok = json5;
      end
      default: prim_ok = 1'b0;
    endcase
    is_val = (tok == TOK_SQ_STR) || (tok == TOK_DQ_STR) ||
             ((tok >= TOK_TRUE) && (tok <= TOK_HEX));
  end

  // Grammar step: next context, stack action and result
  always_comb begin
    logic       do_push;
    logic       do_pop;
    logic       do_prim;
    logic [1:0] push_mode;

    do_push    = 1'b0;
    do_pop     = 1'b0;
    do_prim    = 1'b0;
    push_mode  = MODE_ARRAY;
    st         = ST_BADTOK;
    ev         = EV_NONE;
    bv         = 1'b0;
    val        = '0;
    mode_next  = mode;
    flags_next = flags;
    sp_next    = sp;
    push       = 1'b0;
    push_word  = '0;

    priority if (mode > MODE_OBJECT) begin
      st = ST_BADST;
    end else if (tok == TOK_EOF) begin
      st = (mode == MODE_ROOT) ? ST_EOF : ST_TRUNC;
    end else if (tok == TOK_ERROR) begin
      st = ST_TOKERR;
    end else if (tok == TOK_LCOMMENT || tok == TOK_BCOMMENT) begin
      st = json5 ? ST_COMMENT : ST_BADTOK;
    end else if (mode == MODE_ROOT) begin
      // Root accepts a single value
      if (tok == TOK_LBRACKET || tok == TOK_LBRACE) begin
        if (!flags[2]) begin
          flags_next = flags | F_VALUE;
          ev         = (tok == TOK_LBRACKET) ? EV_ASTA : EV_OSTA;
          push_mode  = (tok == TOK_LBRACKET) ? MODE_ARRAY : MODE_OBJECT;
          do_push    = 1'b1;
        end
      end else if (is_val) begin
        if (!flags[2]) begin
          flags_next = flags | F_VALUE;
          do_prim    = 1'b1;
        end
      end
    end else if (mode == MODE_ARRAY) begin
      // Array: values separated by commas
      if (tok == TOK_COMMA) begin
        if ((flags & F_VC) == F_VALUE) begin
          flags_next = flags | F_COMMA;
          st         = ST_COMMENT;
        end
      end else if (tok == TOK_RBRACKET) begin
        if (!(flags[3] && !json5)) begin
          ev     = EV_AEND;
          do_pop = 1'b1;
        end
      end else if (tok == TOK_LBRACKET || tok == TOK_LBRACE || is_val) begin
        if ((flags & F_VC) == 4'b0000 || (flags & F_VC) == F_VC) begin
          flags_next = F_VALUE;
          if (tok == TOK_LBRACKET || tok == TOK_LBRACE) begin
            ev        = (tok == TOK_LBRACKET) ? EV_ASTA : EV_OSTA;
            push_mode = (tok == TOK_LBRACKET) ? MODE_ARRAY : MODE_OBJECT;
            do_push   = 1'b1;
          end else begin
            do_prim = 1'b1;
          end
        end
      end
    end else begin
      // Object: property, colon, value, comma
      unique case (tok)
        TOK_COMMA: begin
          if (flags == F_PCV) begin
            flags_next = flags | F_COMMA;
            st         = ST_COMMENT;
          end
        end
        TOK_COLON: begin
          if (flags == F_PROP) begin
            flags_next = flags | F_COLON;
            st         = ST_COMMENT;
          end
        end
        TOK_RBRACE: begin
          if ((flags == F_ALL && json5) || flags == 4'b0000 || flags == F_PCV) begin
            ev     = EV_OEND;
            do_pop = 1'b1;
          end
        end
        TOK_LBRACKET, TOK_LBRACE: begin
          if (flags == F_PC) begin
            flags_next = flags | F_VALUE;
            ev         = (tok == TOK_LBRACKET) ? EV_ASTA : EV_OSTA;
            push_mode  = (tok == TOK_LBRACKET) ? MODE_ARRAY : MODE_OBJECT;
            do_push    = 1'b1;
          end
        end
        TOK_SQ_STR, TOK_DQ_STR, TOK_IDENT: begin
          priority if (flags == 4'b0000 || flags == F_ALL) begin
            do_prim = 1'b1;
            if (prim_ok) begin
              flags_next = F_PROP;
            end
          end else if (flags == F_PC) begin
            do_prim = 1'b1;
            if (prim_ok) begin
              flags_next = flags | F_VALUE;
            end
          end else begin
            st = ST_BADST;
          end
        end
        TOK_TRUE, TOK_FALSE, TOK_NULL, TOK_DECIMAL, TOK_DOUBLE, TOK_HEX: begin
          if (flags == F_PC) begin
            flags_next = flags | F_VALUE;
            do_prim    = 1'b1;
          end
        end
        default: st = ST_BADTOK;
      endcase
    end

    // Primitive value event; a property name overrides the kind
    if (do_prim) begin
      if (prim_ok) begin
        st = ST_EVENT;
        ev = (mode == MODE_OBJECT && flags != F_PC) ? EV_PROP : prim_ev;
        bv = (tok == TOK_TRUE);
        if (prim_ev == EV_INT || prim_ev == EV_DBL) begin
          val = bits;
        end
      end else begin
        st = ST_BADTOK;
      end
    end

    // Save the context and enter the new one
    if (do_push) begin
      if (sp >= SP_W'(MAX_DEPTH)) begin
        st = ST_BADST;
      end else begin
        push       = accept;
        push_word  = {mode, flags_next};
        sp_next    = sp + SP_W'(1);
        mode_next  = push_mode;
        flags_next = 4'b0000;
        st         = ST_EVENT;
      end
    end

    // Restore the saved context
    if (do_pop) begin
      if (sp == '0) begin
        st = ST_BADST;
      end else begin
        sp_next    = sp - SP_W'(1);
        mode_next  = top_word[5:4];
        flags_next = top_word[3:0];
        st         = ST_EVENT;
      end
    end

    // Clear the event fields for any non-event status
    if (st != ST_EVENT) begin
      ev  = EV_NONE;
      bv  = 1'b0;
      val = '0;
    end

    // Hold everything when no token is taken
    if (!accept) begin
      mode_next  = mode;
      flags_next = flags;
      sp_next    = sp;
    end
  end

  // Context registers and forwarding of the pushed word
  always_ff @(posedge clk) begin
    if (rst) begin
      json5  <= 1'b0;
      mode   <= MODE_ROOT;
      flags  <= 4'b0000;
      sp     <= '0;
      push_d <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        json5 <= cfg_data;
      end
      mode   <= mode_next;
      flags  <= flags_next;
      sp     <= sp_next;
      push_d <= push;
    end
  end

  always_ff @(posedge clk) begin
    push_word_d <= push_word;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {2'b00, 6'(sp_next), val, bv, ev, st};
    end
  end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// JSON token structure checker - testbench
// Drives token streams into the checker and compares every result word with
// a cycle-free grammar predictor kept inside the bench. Directed sequences
// cover root handling, strict and JSON5 grammar and the error codes.
// A grammar walker produces mostly well-formed random documents inside one
// open top-level array, with some noise, under several idle and stall
// profiles. It also covers stack overflow and a long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import jtsc_pkg::*;

  localparam int          MAX_DEPTH    = 32;
  localparam int          HOLD_CYCLES  = 200;
  localparam int          DRAIN_CYCLES = 4;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          WALK_ITEMS   = 40;
  // Token kinds the package leaves unnamed
  localparam logic [4:0]  TOK_OTHER    = 5'd19;
  localparam logic [4:0]  TOK_TOP_CODE = 5'd31;

  // One result word, status in the low bits as on m_tdata
  typedef struct packed {
    logic [5:0]  depth;
    logic [63:0] value;
    logic        bool_v;
    logic [3:0]  ev;
    logic [2:0]  status;
  } parse_result_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic                  cfg_data  = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;

  // Grammar predictor state
  logic        json5_en;
  logic [1:0]  ctx_mode;
  logic [3:0]  ctx_flags;
  logic [5:0]  ctx_stack [MAX_DEPTH];
  int unsigned stack_ptr;
  logic [3:0]  pend_event;
  logic        pend_bool;
  logic [63:0] pend_value;

  parse_result_t verdict_q [$];

  // Traffic shaping and bookkeeping
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned nest_goal      = 3;
  bit          hold_req       = 1'b0;
  int unsigned errors         = 0;
  int unsigned tokens_sent    = 0;
  int unsigned results_checked = 0;
  int unsigned deepest        = 0;
  int unsigned overflow_hits  = 0;
  int unsigned badst_count    = 0;
  int unsigned badtok_count   = 0;

  json_token_structure_checker_top #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_data (cfg_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Grammar predictor
  // --------------------------------------------------------------------------
  function automatic logic [2:0] push_context(input logic [1:0] mode);
    if (stack_ptr >= MAX_DEPTH) return ST_BADST;
    ctx_stack[stack_ptr] = {ctx_mode, ctx_flags};
    stack_ptr++;
    ctx_mode  = mode;
    ctx_flags = '0;
    return ST_EVENT;
  endfunction

  function automatic logic [2:0] pop_context();
    logic [5:0] word;
    if (stack_ptr == 0) return ST_BADST;
    stack_ptr--;
    word      = ctx_stack[stack_ptr];
    ctx_mode  = word[5:4];
    ctx_flags = word[3:0];
    return ST_EVENT;
  endfunction

  // Classify a scalar and stage its event
  function automatic logic [2:0] classify_scalar(input logic [4:0] kind,
                                                 input logic [63:0] vbits);
    case (kind)
      TOK_DQ_STR: pend_event = EV_STR;
      TOK_TRUE, TOK_FALSE: begin
        pend_event = EV_BOOL;
        pend_bool  = (kind == TOK_TRUE);
      end
      TOK_NULL: pend_event = EV_NULL;
      TOK_DECIMAL: begin
        pend_event = EV_INT;
        pend_value = vbits;
      end
      TOK_DOUBLE: begin
        pend_event = EV_DBL;
        pend_value = vbits;
      end
      TOK_SQ_STR, TOK_IDENT: begin
        if (!json5_en) return ST_BADTOK;
        pend_event = EV_STR;
      end
      TOK_HEX: begin
        if (!json5_en) return ST_BADTOK;
        pend_event = EV_INT;
        pend_value = vbits;
      end
      default: return ST_BADTOK;
    endcase
    return ST_EVENT;
  endfunction

  function automatic bit is_value_kind(input logic [4:0] kind);
    return kind == TOK_SQ_STR || kind == TOK_DQ_STR ||
           (kind >= TOK_TRUE && kind <= TOK_HEX);
  endfunction

  function automatic logic [2:0] root_token(input logic [4:0] kind,
                                            input logic [63:0] vbits);
    if (kind == TOK_LBRACKET || kind == TOK_LBRACE) begin
      if ((ctx_flags & F_VALUE) != '0) return ST_BADTOK;
      pend_event = (kind == TOK_LBRACKET) ? EV_ASTA : EV_OSTA;
      ctx_flags |= F_VALUE;
      return push_context(kind == TOK_LBRACKET ? MODE_ARRAY : MODE_OBJECT);
    end
    if (is_value_kind(kind)) begin
      if ((ctx_flags & F_VALUE) != '0) return ST_BADTOK;
      ctx_flags |= F_VALUE;
      return classify_scalar(kind, vbits);
    end
    return ST_BADTOK;
  endfunction

  function automatic logic [2:0] array_token(input logic [4:0] kind,
                                             input logic [63:0] vbits);
    logic [3:0] f;
    f = ctx_flags & F_VC;
    if (kind == TOK_COMMA) begin
      if (f != F_VALUE) return ST_BADTOK;
      ctx_flags |= F_COMMA;
      return ST_COMMENT;
    end
    if (kind == TOK_RBRACKET) begin
      if ((ctx_flags & F_COMMA) != '0 && !json5_en) return ST_BADTOK;
      pend_event = EV_AEND;
      return pop_context();
    end
    if (kind == TOK_LBRACKET || kind == TOK_LBRACE || is_value_kind(kind)) begin
      if (f != '0 && f != F_VC) return ST_BADTOK;
      ctx_flags = F_VALUE;
      if (kind == TOK_LBRACKET) begin
        pend_event = EV_ASTA;
        return push_context(MODE_ARRAY);
      end
      if (kind == TOK_LBRACE) begin
        pend_event = EV_OSTA;
        return push_context(MODE_OBJECT);
      end
      return classify_scalar(kind, vbits);
    end
    return ST_BADTOK;
  endfunction

  function automatic logic [2:0] object_token(input logic [4:0] kind,
                                              input logic [63:0] vbits);
    logic [3:0] f;
    logic [2:0] st;
    f = ctx_flags;
    case (kind)
      TOK_COMMA: begin
        if (f != F_PCV) return ST_BADTOK;
        ctx_flags |= F_COMMA;
        return ST_COMMENT;
      end
      TOK_COLON: begin
        if (f != F_PROP) return ST_BADTOK;
        ctx_flags |= F_COLON;
        return ST_COMMENT;
      end
      TOK_RBRACE: begin
        if (f == F_ALL) begin
          if (!json5_en) return ST_BADTOK;
        end else if (f != '0 && f != F_PCV) begin
          return ST_BADTOK;
        end
        pend_event = EV_OEND;
        return pop_context();
      end
      TOK_LBRACKET, TOK_LBRACE: begin
        if (f != F_PC) return ST_BADTOK;
        pend_event = (kind == TOK_LBRACKET) ? EV_ASTA : EV_OSTA;
        ctx_flags |= F_VALUE;
        return push_context(kind == TOK_LBRACKET ? MODE_ARRAY : MODE_OBJECT);
      end
      TOK_SQ_STR, TOK_DQ_STR, TOK_IDENT: begin
        // Name position: a rejected name leaves the flags alone
        if (f == '0 || f == F_ALL) begin
          st = classify_scalar(kind, vbits);
          if (st == ST_EVENT) begin
            ctx_flags  = F_PROP;
            pend_event = EV_PROP;
          end
          return st;
        end
        if (f == F_PC) begin
          st = classify_scalar(kind, vbits);
          if (st == ST_EVENT) ctx_flags |= F_VALUE;
          return st;
        end
        // String in the wrong place inside an object
        return ST_BADST;
      end
      TOK_TRUE, TOK_FALSE, TOK_NULL, TOK_DECIMAL, TOK_DOUBLE, TOK_HEX: begin
        if (f != F_PC) return ST_BADTOK;
        ctx_flags |= F_VALUE;
        return classify_scalar(kind, vbits);
      end
      default: return ST_BADTOK;
    endcase
  endfunction

  // Advance the predictor by one token and build its result word
  function automatic parse_result_t json_grammar_step(input logic [4:0] kind,
                                                      input logic [63:0] vbits);
    parse_result_t r;
    logic [2:0]    st;
    pend_event = EV_NONE;
    pend_bool  = 1'b0;
    pend_value = '0;
    if (ctx_mode > MODE_OBJECT)
      st = ST_BADST;
    else if (kind == TOK_EOF)
      st = (ctx_mode == MODE_ROOT) ? ST_EOF : ST_TRUNC;
    else if (kind == TOK_ERROR)
      st = ST_TOKERR;
    else if (kind == TOK_LCOMMENT || kind == TOK_BCOMMENT)
      st = json5_en ? ST_COMMENT : ST_BADTOK;
    else if (ctx_mode == MODE_ROOT)
      st = root_token(kind, vbits);
    else if (ctx_mode == MODE_ARRAY)
      st = array_token(kind, vbits);
    else
      st = object_token(kind, vbits);
    if (st != ST_EVENT) begin
      pend_event = EV_NONE;
      pend_bool  = 1'b0;
      pend_value = '0;
    end
    r.status = st;
    r.ev     = pend_event;
    r.bool_v = pend_bool;
    r.value  = pend_value;
    r.depth  = 6'(stack_ptr);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [63:0] random_bits();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [4:0] random_scalar_kind();
    case ($urandom_range(8))
      0:       return TOK_SQ_STR;
      1:       return TOK_DQ_STR;
      2:       return TOK_IDENT;
      3:       return TOK_TRUE;
      4:       return TOK_FALSE;
      5:       return TOK_NULL;
      6:       return TOK_DECIMAL;
      7:       return TOK_DOUBLE;
      default: return TOK_HEX;
    endcase
  endfunction

  function automatic bit may_close();
    return stack_ptr > 1 && (stack_ptr > nest_goal || $urandom_range(3) == 0);
  endfunction

  function automatic logic [4:0] open_or_scalar();
    if (stack_ptr < nest_goal && $urandom_range(3) != 0)
      return $urandom_range(1) ? TOK_LBRACKET : TOK_LBRACE;
    return random_scalar_kind();
  endfunction

  // Pick the next token from the predicted context: mostly legal, some noise.
  // The top-level array is never closed here, so the run stays in depth.
  function automatic logic [4:0] pick_token();
    int unsigned roll;
    logic [4:0]  kind;
    roll = $urandom_range(99);
    if (roll < 8) begin
      kind = 5'($urandom_range(31));
      if (kind == TOK_RBRACKET && ctx_mode == MODE_ARRAY && stack_ptr <= 1)
        kind = TOK_OTHER;
      return kind;
    end
    if (json5_en && roll < 12) return roll[0] ? TOK_LCOMMENT : TOK_BCOMMENT;
    if (ctx_mode == MODE_ARRAY) begin
      if ((ctx_flags & F_VC) == F_VALUE) return may_close() ? TOK_RBRACKET : TOK_COMMA;
      if ((ctx_flags & F_COMMA) != '0 && json5_en && may_close()) return TOK_RBRACKET;
      return open_or_scalar();
    end
    if (ctx_mode == MODE_OBJECT) begin
      if (ctx_flags == '0 || ctx_flags == F_ALL) begin
        if ((ctx_flags == '0 || json5_en) && may_close()) return TOK_RBRACE;
        if ($urandom_range(3) == 0) return roll[1] ? TOK_SQ_STR : TOK_IDENT;
        return TOK_DQ_STR;
      end
      if (ctx_flags == F_PROP) return TOK_COLON;
      if (ctx_flags == F_PC)   return open_or_scalar();
      if (ctx_flags == F_PCV)  return may_close() ? TOK_RBRACE : TOK_COMMA;
      return TOK_OTHER;
    end
    return TOK_LBRACKET;
  endfunction

  function automatic bit is_open_kind(input logic [4:0] kind);
    return kind == TOK_LBRACKET || kind == TOK_LBRACE;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) $display("MISMATCH: %s", msg);
  endtask

  // Offer one token, hold it until the transfer, then queue its verdict
  task automatic send_token(input logic [4:0] kind, input logic [63:0] vbits);
    parse_result_t want;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, vbits, kind};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    want = json_grammar_step(kind, vbits);
    verdict_q.push_back(want);
    tokens_sent++;
    if (stack_ptr > deepest) deepest = stack_ptr;
    if (want.status == ST_BADST) badst_count++;
    if (want.status == ST_BADTOK) badtok_count++;
    if (want.status == ST_BADST && stack_ptr == MAX_DEPTH && is_open_kind(kind))
      overflow_hits++;
  endtask

  // Stop offering and wait for every verdict to come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_json5(input logic en);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    json5_en = en;
  endtask

  task automatic apply_idle_profile(input int unsigned profile);
    case (profile)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 47; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 47; end
      default: begin src_idle_pct = 37; sink_stall_pct = 37; end
    endcase
  endtask

  task automatic walk_tokens(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 16 == 0)
        nest_goal = ($urandom_range(7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
      send_token(pick_token(), random_bits());
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Root handling and strict grammar; leaves the top-level array open
  task automatic test_root_and_strict_grammar();
    write_json5(1'b0);
    send_token(TOK_EOF, '1);              // end of input at root
    send_token(TOK_ERROR, '0);
    send_token(TOK_LCOMMENT, random_bits());
    send_token(TOK_BCOMMENT, random_bits());
    send_token(TOK_COLON, random_bits());
    send_token(TOK_LBRACKET, random_bits());
    send_token(TOK_DECIMAL, '0);
    send_token(TOK_DOUBLE, '1);           // missing comma
    send_token(TOK_COMMA, random_bits());
    send_token(TOK_HEX, '1);              // rejected, value flag stays set
    send_token(TOK_COMMA, random_bits());
    send_token(TOK_RBRACKET, random_bits()); // trailing comma not allowed
    send_token(TOK_LBRACE, random_bits());
    send_token(TOK_DQ_STR, random_bits());
    send_token(TOK_SQ_STR, random_bits());   // string right after a name
    send_token(TOK_COLON, random_bits());
    send_token(TOK_DOUBLE, 64'h8000_0000_0000_0001);
    send_token(TOK_COMMA, random_bits());
    send_token(TOK_IDENT, random_bits());    // name rejected, flags kept
    send_token(TOK_RBRACE, random_bits());   // trailing comma not allowed
    send_token(TOK_DQ_STR, random_bits());
    send_token(TOK_COLON, random_bits());
    send_token(TOK_TRUE, random_bits());
    send_token(TOK_RBRACE, random_bits());
    send_token(TOK_EOF, random_bits());      // truncated input
    send_token(TOK_OTHER, random_bits());
    send_token(TOK_TOP_CODE, random_bits());
  endtask

  task automatic test_json5_relaxations();
    write_json5(1'b1);
    send_token(TOK_LCOMMENT, random_bits());
    send_token(TOK_BCOMMENT, random_bits());
    send_token(TOK_COMMA, random_bits());
    send_token(TOK_SQ_STR, random_bits());
    send_token(TOK_COMMA, random_bits());
    send_token(TOK_HEX, 64'hFFFF_FFFF_0000_0000);
    send_token(TOK_COMMA, random_bits());
    send_token(TOK_IDENT, random_bits());    // identifier is no array value
    send_token(TOK_LBRACE, random_bits());
    send_token(TOK_IDENT, random_bits());
    send_token(TOK_COLON, random_bits());
    send_token(TOK_FALSE, random_bits());
    send_token(TOK_COMMA, random_bits());
    send_token(TOK_RBRACE, random_bits());   // trailing comma allowed
    send_token(TOK_COMMA, random_bits());
    send_token(TOK_LBRACKET, random_bits());
    send_token(TOK_NULL, random_bits());
    send_token(TOK_COMMA, random_bits());
    send_token(TOK_RBRACKET, random_bits());
  endtask

  // Random documents under each idle profile, alternating the grammar mode
  task automatic test_random_walk();
    for (int unsigned p = 0; p < 8; p++) begin
      write_json5(p[0]);
      apply_idle_profile(p >> 1);
      walk_tokens(WALK_ITEMS);
    end
  endtask

  // Nest until the saved-context stack overflows, then unwind
  task automatic test_deep_nesting();
    int unsigned start_hits;
    write_json5(1'($urandom_range(1)));
    apply_idle_profile(3);
    start_hits = overflow_hits;
    nest_goal  = MAX_DEPTH + 2;
    for (int n = 0; n < 800 && overflow_hits < start_hits + 2; n++)
      send_token(pick_token(), random_bits());
    nest_goal = 1;
    for (int n = 0; n < 800 && stack_ptr > 1; n++)
      send_token(pick_token(), random_bits());
  endtask

  // Receiver holds off while tokens keep coming, so the input must stall
  task automatic test_output_hold_off();
    apply_idle_profile(0);
    hold_req = 1'b1;
    walk_tokens(WALK_ITEMS);
  endtask

  // Close everything back to root, then probe the finished document
  task automatic test_document_close();
    write_json5(1'b1);
    apply_idle_profile(3);
    while (stack_ptr != 0) begin
      if (ctx_mode == MODE_ARRAY)
        send_token(TOK_RBRACKET, random_bits());
      else if (ctx_flags == F_PROP)
        send_token(TOK_COLON, random_bits());
      else if (ctx_flags == F_PC)
        send_token(TOK_NULL, random_bits());
      else
        send_token(TOK_RBRACE, random_bits());
    end
    send_token(TOK_EOF, random_bits());
    send_token(TOK_DECIMAL, random_bits());   // second top-level value
    send_token(TOK_RBRACKET, random_bits());
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : sink_drive
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Compare each result transfer with the oldest verdict
  always @(posedge clk) begin : result_check
    parse_result_t got;
    parse_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[77:0];
      results_checked++;
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("result %0d with no token pending", results_checked));
      end else begin
        want = verdict_q.pop_front();
        if (got.status != want.status)
          report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                    results_checked, got.status, want.status));
        if (got.ev != want.ev)
          report_mismatch($sformatf("result %0d: event %0d, expected %0d",
                                    results_checked, got.ev, want.ev));
        if (got.bool_v != want.bool_v)
          report_mismatch($sformatf("result %0d: bool %0d, expected %0d",
                                    results_checked, got.bool_v, want.bool_v));
        if (got.value != want.value)
          report_mismatch($sformatf("result %0d: value %h, expected %h",
                                    results_checked, got.value, want.value));
        if (got.depth != want.depth)
          report_mismatch($sformatf("result %0d: depth %0d, expected %0d",
                                    results_checked, got.depth, want.depth));
      end
    end
  end

  // Watchdog: count cycles with no transfer on any channel
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("timeout: no transfer for %0d cycles, %0d results outstanding",
             STALL_LIMIT, verdict_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    json5_en  = 1'b0;
    ctx_mode  = MODE_ROOT;
    ctx_flags = '0;
    stack_ptr = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_root_and_strict_grammar();
    test_json5_relaxations();
    test_random_walk();
    test_deep_nesting();
    test_output_hold_off();
    test_document_close();
    wait_drained();

    $display("Checked %0d results for %0d tokens, strict and JSON5, four idle profiles.",
             results_checked, tokens_sent);
    $display("Deepest nesting %0d, %0d stack overflows, %0d bad-state, %0d bad-token.",
             deepest, overflow_hits, badst_count, badtok_count);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/jtsc_pkg.sv
hdl/jtsc_ram.sv
hdl/json_token_structure_checker_top.sv
sim/tb.sv
